>>> src/tps_pkg.sv
// Shared constants for the triangle/plane slicer: default widths,
// configuration register indexes and result status codes. No dependencies.
package tps_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int NORM_W          = 19;  // plane normal components
  localparam int REG_W           = 32;  // widest configuration register
  localparam int CFG_IDX_W       = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Y  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_POINT_Z  = 3'd6;

  localparam logic [1:0] ST_SEG   = 2'd0;  // segment found
  localparam logic [1:0] ST_ON    = 2'd1;  // triangle lies on plane
  localparam logic [1:0] ST_BELOW = 2'd2;  // fully below
  localparam logic [1:0] ST_NONE  = 2'd3;  // above, or touches at one vertex

endpackage

>>> src/triangle_plane_slice.sv
// Top level of the triangle/plane slicer: config registers, projection and
// classification stages, per-coordinate crossing lanes. Uses tps_pkg, tps_cut_lane.
//
//  port group | dir    | handshake           | content
//  in_*       | input  | in_valid/in_ready   | three vertices a, b, c (x, y, z)
//  out_*      | output | out_valid/out_ready | status, segment start and end
//  cfg_*      | input  | cfg_we              | normal, offset, plane point
//
// One item per cycle unless the output item waits; each crossing lane divides with
// one quotient bit per stage, COORD_WIDTH+1 stages.
// Reset is synchronous: clears valid bits and restores the plane registers.
// The whole pipeline holds while the output item waits; nothing is dropped.
module triangle_plane_slice #(
  parameter int COORD_WIDTH = tps_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = tps_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_z,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_z,
  input  logic signed [COORD_WIDTH-1:0] in_c_x,
  input  logic signed [COORD_WIDTH-1:0] in_c_y,
  input  logic signed [COORD_WIDTH-1:0] in_c_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic signed [COORD_WIDTH-1:0] out_start_x,
  output logic signed [COORD_WIDTH-1:0] out_start_y,
  output logic signed [COORD_WIDTH-1:0] out_start_z,
  output logic signed [COORD_WIDTH-1:0] out_end_x,
  output logic signed [COORD_WIDTH-1:0] out_end_y,
  output logic signed [COORD_WIDTH-1:0] out_end_z,
  input  logic                          cfg_we,
  input  logic [tps_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tps_pkg::REG_W-1:0]     cfg_wdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int NW    = tps_pkg::NORM_W;
  localparam int RW    = tps_pkg::REG_W;
  localparam int XW    = (CW > RW) ? CW : RW;
  localparam int MW    = XW + NW;
  localparam int PW    = MW + 2 - FRAC_BITS;
  localparam int EW    = ((PW > RW) ? PW : RW) + 1;
  localparam int NMW   = PW + 1;
  localparam int HL    = (NMW + 1) / 2;
  localparam int HH    = NMW - HL;
  localparam int QB    = CW + 1;
  localparam int LW    = QB + NMW;
  localparam int DEPTH = QB + 10;

  // ---------------- configuration ----------------
  logic signed [NW-1:0] nrm_r [3];
  logic signed [RW-1:0] off_r;
  logic signed [RW-1:0] pt_r  [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r[0] <= '0;
      nrm_r[1] <= NW'(1) << FRAC_BITS;
      nrm_r[2] <= '0;
      off_r    <= '0;
      pt_r[0]  <= '0;
      pt_r[1]  <= '0;
      pt_r[2]  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tps_pkg::CFG_NORMAL_X: nrm_r[0] <= cfg_wdata[NW-1:0];
        tps_pkg::CFG_NORMAL_Y: nrm_r[1] <= cfg_wdata[NW-1:0];
        tps_pkg::CFG_NORMAL_Z: nrm_r[2] <= cfg_wdata[NW-1:0];
        tps_pkg::CFG_OFFSET:   off_r    <= cfg_wdata;
        tps_pkg::CFG_POINT_X:  pt_r[0]  <= cfg_wdata;
        tps_pkg::CFG_POINT_Y:  pt_r[1]  <= cfg_wdata;
        tps_pkg::CFG_POINT_Z:  pt_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------- flow control ----------------
  logic [DEPTH-1:0] vld_r;
  logic             en;

  assign en        = !vld_r[DEPTH-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  logic signed [CW-1:0] vin [3][3];
  assign vin[0][0] = in_a_x;
  assign vin[0][1] = in_a_y;
  assign vin[0][2] = in_a_z;
  assign vin[1][0] = in_b_x;
  assign vin[1][1] = in_b_y;
  assign vin[1][2] = in_b_z;
  assign vin[2][0] = in_c_x;
  assign vin[2][1] = in_c_y;
  assign vin[2][2] = in_c_z;

  // ---------------- stage 1: products with the normal ----------------
  // point 3 is the configured plane point
  logic signed [MW-1:0] prod1_r [4][3];
  logic signed [CW-1:0] v1_r    [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        for (int p = 0; p < 3; p++) begin
          prod1_r[p][k] <= MW'(vin[p][k]) * MW'(nrm_r[k]);
          v1_r[p][k]    <= vin[p][k];
        end
        prod1_r[3][k] <= MW'(pt_r[k]) * MW'(nrm_r[k]);
      end
    end
  end

  // ---------------- stage 2: floor of the dot product ----------------
  logic signed [MW+1:0] sum2  [4];
  logic signed [PW-1:0] proj2_r [4];
  logic signed [CW-1:0] v2_r  [3][3];

  for (genvar p = 0; p < 4; p++) begin : g_sum
    assign sum2[p] = (MW+2)'(prod1_r[p][0]) + (MW+2)'(prod1_r[p][1])
                   + (MW+2)'(prod1_r[p][2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 4; p++) begin
        proj2_r[p] <= PW'(sum2[p] >>> FRAC_BITS);
      end
      v2_r <= v1_r;
    end
  end

  // ---------------- stage 3: side of the plane ----------------
  logic signed [PW-1:0] proj3_r [4];
  logic signed [CW-1:0] v3_r    [3][3];
  logic [2:0]           lt3_r;
  logic [2:0]           eq3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int p = 0; p < 3; p++) begin
        lt3_r[p] <= (EW'(proj2_r[p]) <  EW'(off_r));
        eq3_r[p] <= (EW'(proj2_r[p]) == EW'(off_r));
      end
      proj3_r <= proj2_r;
      v3_r    <= v2_r;
    end
  end

  // ---------------- stage 4: classify and pick the edges ----------------
  function automatic logic opp(input logic lx, input logic ex, input logic ly,
                               input logic ey);
    return (lx && !ly && !ey) || (ly && !lx && !ex);
  endfunction

  function automatic logic signed [PW-1:0] pick_p(input logic [1:0] sel,
      input logic signed [PW-1:0] x0, input logic signed [PW-1:0] x1,
      input logic signed [PW-1:0] x2);
    case (sel)
      2'd1:    return x1;
      2'd2:    return x2;
      default: return x0;
    endcase
  endfunction

  function automatic logic signed [CW-1:0] pick_v(input logic [1:0] sel,
      input logic signed [CW-1:0] x0, input logic signed [CW-1:0] x1,
      input logic signed [CW-1:0] x2);
    case (sel)
      2'd1:    return x1;
      2'd2:    return x2;
      default: return x0;
    endcase
  endfunction

  logic [1:0] st4;
  logic [1:0] sel_i [2];
  logic [1:0] sel_j [2];
  logic [2:0] lt;
  logic [2:0] eq;

  assign lt = lt3_r;
  assign eq = eq3_r;

  // a vertex endpoint is an edge from the vertex to itself: l is zero
  always_comb begin
    st4      = tps_pkg::ST_SEG;
    sel_i[0] = 2'd0;
    sel_j[0] = 2'd0;
    sel_i[1] = 2'd0;
    sel_j[1] = 2'd0;
    if (&eq) begin
      st4 = tps_pkg::ST_ON;
    end else if (&lt) begin
      st4 = tps_pkg::ST_BELOW;
    end else if (&(~lt & ~eq)) begin
      st4 = tps_pkg::ST_NONE;
    end else if (eq[0]) begin
      if (eq[1]) begin
        sel_i[1] = 2'd1; sel_j[1] = 2'd1;
      end else if (eq[2]) begin
        sel_i[1] = 2'd2; sel_j[1] = 2'd2;
      end else if (opp(lt[1], eq[1], lt[2], eq[2])) begin
        sel_i[1] = 2'd1; sel_j[1] = 2'd2;
      end else begin
        st4 = tps_pkg::ST_NONE;
      end
    end else if (eq[1]) begin
      sel_i[0] = 2'd1; sel_j[0] = 2'd1;
      if (eq[2]) begin
        sel_i[1] = 2'd2; sel_j[1] = 2'd2;
      end else if (opp(lt[0], eq[0], lt[2], eq[2])) begin
        sel_i[1] = 2'd0; sel_j[1] = 2'd2;
      end else begin
        st4 = tps_pkg::ST_NONE;
      end
    end else if (eq[2]) begin
      sel_i[0] = 2'd2; sel_j[0] = 2'd2;
      if (opp(lt[0], eq[0], lt[1], eq[1])) begin
        sel_i[1] = 2'd0; sel_j[1] = 2'd1;
      end else begin
        st4 = tps_pkg::ST_NONE;
      end
    end else if (opp(lt[0], eq[0], lt[1], eq[1])) begin
      sel_i[0] = 2'd0; sel_j[0] = 2'd1;
      if (opp(lt[1], eq[1], lt[2], eq[2])) begin
        sel_i[1] = 2'd1; sel_j[1] = 2'd2;
      end else begin
        sel_i[1] = 2'd0; sel_j[1] = 2'd2;
      end
    end else begin
      sel_i[0] = 2'd0; sel_j[0] = 2'd2;
      sel_i[1] = 2'd1; sel_j[1] = 2'd2;
    end
  end

  logic signed [NMW-1:0] num4_r [2];
  logic signed [NMW-1:0] den4_r [2];
  logic signed [CW:0]    l4_r   [2][3];
  logic signed [CW-1:0]  a4_r   [2][3];
  logic [1:0]            st_r   [QB+6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < 2; s++) begin
        num4_r[s] <= NMW'(proj3_r[3])
                   - NMW'(pick_p(sel_i[s], proj3_r[0], proj3_r[1], proj3_r[2]));
        den4_r[s] <= NMW'(pick_p(sel_i[s], proj3_r[0], proj3_r[1], proj3_r[2]))
                   - NMW'(pick_p(sel_j[s], proj3_r[0], proj3_r[1], proj3_r[2]));
        for (int k = 0; k < 3; k++) begin
          a4_r[s][k] <= pick_v(sel_i[s], v3_r[0][k], v3_r[1][k], v3_r[2][k]);
          l4_r[s][k] <= (CW+1)'(pick_v(sel_i[s], v3_r[0][k], v3_r[1][k], v3_r[2][k]))
                      - (CW+1)'(pick_v(sel_j[s], v3_r[0][k], v3_r[1][k], v3_r[2][k]));
        end
      end
      st_r[0] <= st4;
      for (int i = 1; i < QB + 6; i++) begin
        st_r[i] <= st_r[i-1];
      end
    end
  end

  // ---------------- stage 5: magnitudes and signs ----------------
  logic [NMW-1:0]       nm5_r   [2];
  logic [NMW-1:0]       dm5_r   [2];
  logic [CW:0]          lm5_r   [6];
  logic                 neg5_r  [6];
  logic                 zero5_r [6];
  logic signed [CW-1:0] a5_r    [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < 2; s++) begin
        nm5_r[s] <= num4_r[s][NMW-1] ? NMW'(-num4_r[s]) : NMW'(num4_r[s]);
        dm5_r[s] <= den4_r[s][NMW-1] ? NMW'(-den4_r[s]) : NMW'(den4_r[s]);
        for (int k = 0; k < 3; k++) begin
          lm5_r[3*s+k]   <= l4_r[s][k][CW] ? (CW+1)'(-l4_r[s][k])
                                           : (CW+1)'(l4_r[s][k]);
          neg5_r[3*s+k]  <= l4_r[s][k][CW] ^ num4_r[s][NMW-1] ^ den4_r[s][NMW-1];
          zero5_r[3*s+k] <= (l4_r[s][k] == '0) || (num4_r[s] == '0);
          a5_r[3*s+k]    <= a4_r[s][k];
        end
      end
    end
  end

  // ---------------- stage 6: partial products ----------------
  logic [CW+HL:0]       pl6_r   [6];
  logic [CW+HH:0]       ph6_r   [6];
  logic [NMW-1:0]       dm6_r   [6];
  logic                 neg6_r  [6];
  logic                 zero6_r [6];
  logic signed [CW-1:0] a6_r    [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 6; n++) begin
        pl6_r[n]   <= (CW+HL+1)'(lm5_r[n]) * (CW+HL+1)'(nm5_r[n/3][HL-1:0]);
        ph6_r[n]   <= (CW+HH+1)'(lm5_r[n]) * (CW+HH+1)'(nm5_r[n/3][NMW-1:HL]);
        dm6_r[n]   <= dm5_r[n/3];
        neg6_r[n]  <= neg5_r[n];
        zero6_r[n] <= zero5_r[n];
        a6_r[n]    <= a5_r[n];
      end
    end
  end

  // ---------------- stage 7: full product ----------------
  logic [LW-1:0]        p7_r    [6];
  logic [NMW-1:0]       dm7_r   [6];
  logic                 neg7_r  [6];
  logic                 zero7_r [6];
  logic signed [CW-1:0] a7_r    [6];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 6; n++) begin
        p7_r[n]    <= LW'(pl6_r[n]) + (LW'(ph6_r[n]) << HL);
        dm7_r[n]   <= dm6_r[n];
        neg7_r[n]  <= neg6_r[n];
        zero7_r[n] <= zero6_r[n];
        a7_r[n]    <= a6_r[n];
      end
    end
  end

  // ---------------- crossing lanes: start x,y,z then end x,y,z ----------------
  logic signed [CW-1:0] res [6];

  for (genvar n = 0; n < 6; n++) begin : g_lane
    tps_cut_lane #(
      .CW  (CW),
      .NMW (NMW)
    ) u_lane (
      .clk    (clk),
      .en     (en),
      .a_i    (a7_r[n]),
      .prod_i (p7_r[n]),
      .den_i  (dm7_r[n]),
      .neg_i  (neg7_r[n]),
      .zero_i (zero7_r[n]),
      .res_o  (res[n])
    );
  end

  // ---------------- output register ----------------
  logic [1:0]           status_r;
  logic signed [CW-1:0] pt_out_r [6];
  logic                 seg;

  assign seg = (st_r[QB+5] == tps_pkg::ST_SEG);

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= st_r[QB+5];
      for (int n = 0; n < 6; n++) begin
        pt_out_r[n] <= seg ? res[n] : '0;
      end
    end
  end

  assign out_status  = status_r;
  assign out_start_x = pt_out_r[0];
  assign out_start_y = pt_out_r[1];
  assign out_start_z = pt_out_r[2];
  assign out_end_x   = pt_out_r[3];
  assign out_end_y   = pt_out_r[4];
  assign out_end_z   = pt_out_r[5];

`ifndef ASSERT_OFF
  a_no_seg_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != tps_pkg::ST_SEG) |->
      (out_start_x == '0) && (out_start_y == '0) && (out_start_z == '0) &&
      (out_end_x == '0) && (out_end_y == '0) && (out_end_z == '0))
    else $error("non-segment item carries endpoint data");

  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during a stall");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

>>> src/tps_cut_lane.sv
// One edge-crossing coordinate: pipelined restoring divide of |l*num| by |den|,
// one quotient bit per stage, then saturate and add to the edge vertex.
// Uses tps_pkg for its default width; used by triangle_plane_slice.
module tps_cut_lane #(
  parameter int CW  = tps_pkg::COORD_WIDTH_DEF,
  parameter int NMW = 38
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] a_i,
  input  logic [CW+NMW:0]      prod_i,
  input  logic [NMW-1:0]       den_i,
  input  logic                 neg_i,
  input  logic                 zero_i,
  output logic signed [CW-1:0] res_o
);

  localparam int QB = CW + 1;
  localparam int LW = QB + NMW;
  localparam logic [QB-1:0] CAP = {1'b1, {CW{1'b0}}};
  localparam logic signed [CW+1:0] TOPV = {3'b000, {(CW-1){1'b1}}};
  localparam logic signed [CW+1:0] BOTV = {3'b111, {(CW-1){1'b0}}};

  logic [NMW-1:0]       rem_r  [QB+1];
  logic [NMW-1:0]       den_r  [QB+1];
  logic [QB-1:0]        pl_r   [QB+1];
  logic [QB-1:0]        q_r    [QB+1];
  logic                 sat_r  [QB+1];
  logic                 neg_r  [QB+1];
  logic                 zero_r [QB+1];
  logic signed [CW-1:0] a_r    [QB+1];
  logic signed [CW-1:0] res_r;

  // quotient at or above 2^QB (zero divisor included) saturates up front
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= prod_i[LW-1:QB];
      den_r[0]  <= den_i;
      pl_r[0]   <= prod_i[QB-1:0];
      q_r[0]    <= '0;
      sat_r[0]  <= (prod_i[LW-1:QB] >= den_i);
      neg_r[0]  <= neg_i;
      zero_r[0] <= zero_i;
      a_r[0]    <= a_i;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_step
    logic [NMW:0] t;
    logic [NMW:0] diff;
    logic         ge;
    assign t    = {rem_r[k], pl_r[k][QB-1]};
    assign ge   = (t >= {1'b0, den_r[k]});
    assign diff = t - {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[NMW-1:0] : t[NMW-1:0];
        den_r[k+1]  <= den_r[k];
        pl_r[k+1]   <= {pl_r[k][QB-2:0], 1'b0};
        q_r[k+1]    <= {q_r[k][QB-2:0], ge};
        sat_r[k+1]  <= sat_r[k];
        neg_r[k+1]  <= neg_r[k];
        zero_r[k+1] <= zero_r[k];
        a_r[k+1]    <= a_r[k];
      end
    end
  end

  logic [QB-1:0]          qe;
  logic signed [CW+1:0]   aext;
  logic signed [CW+1:0]   qext;
  logic signed [CW+1:0]   sum;
  logic signed [CW+1:0]   clp;

  always_comb begin
    if (zero_r[QB]) begin
      qe = '0;
    end else if (sat_r[QB] || q_r[QB] > CAP) begin
      qe = CAP;
    end else begin
      qe = q_r[QB];
    end
    aext = (CW+2)'(a_r[QB]);
    qext = $signed({1'b0, qe});
    sum  = neg_r[QB] ? aext - qext : aext + qext;
    if (sum > TOPV) begin
      clp = TOPV;
    end else if (sum < BOTV) begin
      clp = BOTV;
    end else begin
      clp = sum;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= clp[CW-1:0];
    end
  end

  assign res_o = res_r;

endmodule

>>> verif/triangle_plane_slice_test.sv
// Testbench for triangle_plane_slice: directed and random triangles under several
// plane settings and idle patterns, checked against an in-bench slicing predictor.
// Depends on tps_pkg and the triangle_plane_slice RTL.
`timescale 1ns / 1ps

module triangle_plane_slice_test;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE = CW + 20;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam logic [127:0] QCAP = 128'h1_0000_0000;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0][CW-1:0] pt;  // start x,y,z then end x,y,z
  } slice_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_a_x = '0, in_a_y = '0, in_a_z = '0;
  logic signed [CW-1:0] in_b_x = '0, in_b_y = '0, in_b_z = '0;
  logic signed [CW-1:0] in_c_x = '0, in_c_y = '0, in_c_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [CW-1:0] out_start_x, out_start_y, out_start_z;
  logic signed [CW-1:0] out_end_x, out_end_y, out_end_z;
  logic cfg_we = 1'b0;
  logic [tps_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [tps_pkg::REG_W-1:0] cfg_wdata = '0;

  triangle_plane_slice dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // plane registers as the block should hold them
  longint nrm[3];
  longint plane_off;
  longint ppt[3];
  longint tgt[3];  // coordinate that puts a vertex on the plane, for axis normals

  // per-item scratch for the predictor
  longint vtx[3][3];
  longint prj[3];
  longint pproj;
  longint seg[2][3];

  slice_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  function automatic longint dot_n(longint x, longint y, longint z);
    return (x * nrm[0] + y * nrm[1] + z * nrm[2]) >>> FB;
  endfunction

  function automatic logic [127:0] mag128(longint x);
    longint m;
    m = (x < 0) ? -x : x;
    return 128'(m);
  endfunction

  function automatic longint cut_coord(longint a, longint b, longint num, longint den);
    longint l, r;
    logic [127:0] prod, quot, q;
    bit neg;
    l = a - b;
    neg = ((l < 0) != (num < 0)) != (den < 0);
    if (l == 0 || num == 0) begin
      q = '0;
    end else if (den == 0) begin
      q = QCAP;
    end else begin
      prod = mag128(l) * mag128(num);
      quot = prod / mag128(den);
      q = (quot > QCAP) ? QCAP : quot;
    end
    r = neg ? a - longint'(q[63:0]) : a + longint'(q[63:0]);
    if (r > COORD_MAX) r = COORD_MAX;
    if (r < COORD_MIN) r = COORD_MIN;
    return r;
  endfunction

  function automatic void put_vertex(int i, int w);
    for (int k = 0; k < 3; k++) seg[w][k] = vtx[i][k];
  endfunction

  function automatic void put_cross(int i, int j, int w);
    longint num, den;
    num = pproj - prj[i];
    den = prj[i] - prj[j];
    for (int k = 0; k < 3; k++) seg[w][k] = cut_coord(vtx[i][k], vtx[j][k], num, den);
  endfunction

  function automatic bit opposite(longint x, longint y);
    return (x < 0 && y > 0) || (x > 0 && y < 0);
  endfunction

  function automatic logic [1:0] classify();
    longint d1, d2, d3;
    for (int k = 0; k < 3; k++) prj[k] = dot_n(vtx[k][0], vtx[k][1], vtx[k][2]);
    pproj = dot_n(ppt[0], ppt[1], ppt[2]);
    d1 = prj[0] - plane_off;
    d2 = prj[1] - plane_off;
    d3 = prj[2] - plane_off;
    if (d1 == 0 && d2 == 0 && d3 == 0) return tps_pkg::ST_ON;
    if (d1 < 0 && d2 < 0 && d3 < 0) return tps_pkg::ST_BELOW;
    if (d1 > 0 && d2 > 0 && d3 > 0) return tps_pkg::ST_NONE;
    if (d1 == 0) begin
      if (d2 == 0) begin
        put_vertex(0, 0); put_vertex(1, 1); return tps_pkg::ST_SEG;
      end
      if (d3 == 0) begin
        put_vertex(0, 0); put_vertex(2, 1); return tps_pkg::ST_SEG;
      end
      if (opposite(d2, d3)) begin
        put_vertex(0, 0); put_cross(1, 2, 1); return tps_pkg::ST_SEG;
      end
      return tps_pkg::ST_NONE;
    end
    if (d2 == 0) begin
      if (d3 == 0) begin
        put_vertex(1, 0); put_vertex(2, 1); return tps_pkg::ST_SEG;
      end
      if (opposite(d1, d3)) begin
        put_vertex(1, 0); put_cross(0, 2, 1); return tps_pkg::ST_SEG;
      end
      return tps_pkg::ST_NONE;
    end
    if (d3 == 0) begin
      if (opposite(d1, d2)) begin
        put_vertex(2, 0); put_cross(0, 1, 1); return tps_pkg::ST_SEG;
      end
      return tps_pkg::ST_NONE;
    end
    if (opposite(d1, d2)) begin
      put_cross(0, 1, 0);
      if (opposite(d2, d3)) put_cross(1, 2, 1);
      else put_cross(0, 2, 1);
    end else begin
      put_cross(0, 2, 0);
      put_cross(1, 2, 1);
    end
    return tps_pkg::ST_SEG;
  endfunction

  function automatic slice_t predict_slice(logic [8:0][CW-1:0] tri_in);
    slice_t res;
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++) vtx[i][k] = longint'(signed'(tri_in[i * 3 + k]));
    for (int w = 0; w < 2; w++)
      for (int k = 0; k < 3; k++) seg[w][k] = 0;
    res.status = classify();
    for (int k = 0; k < 3; k++) begin
      res.pt[k]     = (res.status == tps_pkg::ST_SEG) ? seg[0][k][CW-1:0] : '0;
      res.pt[3 + k] = (res.status == tps_pkg::ST_SEG) ? seg[1][k][CW-1:0] : '0;
    end
    return res;
  endfunction

  // receiver stalls
  always @(negedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    slice_t got, exp_r;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results outstanding", $time, expected_q.size());
      $display("TEST FAILED");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      got.status = out_status;
      got.pt = {out_end_z, out_end_y, out_end_x, out_start_z, out_start_y, out_start_x};
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result status %0d", $time, got.status);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.status !== exp_r.status) begin
          $display("%0t status: expected %0d actual %0d", $time, exp_r.status, got.status);
          errors++;
        end
        for (int k = 0; k < 6; k++)
          if (got.pt[k] !== exp_r.pt[k]) begin
            $display("%0t %s_%s: expected %h actual %h", $time, (k < 3) ? "start" : "end",
                     (k % 3 == 0) ? "x" : (k % 3 == 1) ? "y" : "z", exp_r.pt[k], got.pt[k]);
            errors++;
          end
      end
    end
  end

  // entered and left just after a falling edge
  task automatic send_tri(logic [8:0][CW-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_c_z, in_c_y, in_c_x, in_b_z, in_b_y, in_b_x, in_a_z, in_a_y, in_a_x} <= t;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_slice(t));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [tps_pkg::CFG_IDX_W-1:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val[tps_pkg::REG_W-1:0];
    case (idx)
      tps_pkg::CFG_NORMAL_X: nrm[0] = longint'(signed'(val[tps_pkg::NORM_W-1:0]));
      tps_pkg::CFG_NORMAL_Y: nrm[1] = longint'(signed'(val[tps_pkg::NORM_W-1:0]));
      tps_pkg::CFG_NORMAL_Z: nrm[2] = longint'(signed'(val[tps_pkg::NORM_W-1:0]));
      tps_pkg::CFG_OFFSET:   plane_off = longint'(signed'(val[31:0]));
      tps_pkg::CFG_POINT_X:  ppt[0] = longint'(signed'(val[31:0]));
      tps_pkg::CFG_POINT_Y:  ppt[1] = longint'(signed'(val[31:0]));
      tps_pkg::CFG_POINT_Z:  ppt[2] = longint'(signed'(val[31:0]));
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_plane(longint nx, longint ny, longint nz, longint off,
                           longint px, longint py, longint pz);
    wait_drained();
    cfg_write(tps_pkg::CFG_NORMAL_X, nx);
    cfg_write(tps_pkg::CFG_NORMAL_Y, ny);
    cfg_write(tps_pkg::CFG_NORMAL_Z, nz);
    cfg_write(tps_pkg::CFG_OFFSET, off);
    cfg_write(tps_pkg::CFG_POINT_X, px);
    cfg_write(tps_pkg::CFG_POINT_Y, py);
    cfg_write(tps_pkg::CFG_POINT_Z, pz);
    cfg_we <= 1'b0;
    for (int k = 0; k < 3; k++)
      case (nrm[k])
        64'sd65536:   tgt[k] = plane_off;
        -64'sd65536:  tgt[k] = -plane_off;
        64'sd131072:  tgt[k] = plane_off >>> 1;
        -64'sd131072: tgt[k] = -(plane_off >>> 1);
        default:      tgt[k] = 0;
      endcase
  endtask

  function automatic longint rand_coord(int axis);
    int r;
    r = $urandom_range(9);
    if (r <= 3) return tgt[axis];
    if (r <= 6) return tgt[axis] + longint'($urandom_range(16)) - 8;
    if (r == 7) return longint'(signed'(32'($urandom)));
    if (r == 8) return $urandom_range(1) ? COORD_MAX : COORD_MIN;
    return longint'($urandom_range(2097152)) - 1048576;
  endfunction

  function automatic logic [8:0][CW-1:0] rand_tri();
    logic [8:0][CW-1:0] t;
    longint v;
    for (int i = 0; i < 9; i++) begin
      v = rand_coord(i % 3);
      t[i] = v[CW-1:0];
    end
    return t;
  endfunction

  function automatic logic [8:0][CW-1:0] mk_tri(longint ax, longint ay, longint az,
      longint bx, longint by, longint bz, longint cx, longint cy, longint cz);
    return {cz[CW-1:0], cy[CW-1:0], cx[CW-1:0], bz[CW-1:0], by[CW-1:0], bx[CW-1:0],
            az[CW-1:0], ay[CW-1:0], ax[CW-1:0]};
  endfunction

  // reset plane is y = 0; heights below are in Q16.16
  task automatic test_classes();
    longint one;
    one = 64'sd65536;
    send_tri(mk_tri(1, 0, 2, 5 * one, 0, -3, -7, 0, one));                   // on plane
    send_tri(mk_tri(0, -one, 0, one, -2, 0, 0, -5 * one, one));             // below
    send_tri(mk_tri(0, one, 0, one, 2, 0, 0, 5 * one, one));                // above
    send_tri(mk_tri(0, 0, 0, one, one, 0, 0, 2 * one, one));                // one vertex touches
    send_tri(mk_tri(0, 0, 0, one, 0, 0, 0, one, one));                      // edge a-b on plane
    send_tri(mk_tri(0, 0, 0, one, one, 0, 3, 0, one));                      // edge a-c on plane
    send_tri(mk_tri(0, one, 0, 4, 0, 0, 5, 0, one));                        // edge b-c on plane
    send_tri(mk_tri(0, 0, 0, one, one, 0, one, -one, one));                 // a on plane, cut b-c
    send_tri(mk_tri(one, one, 0, 0, 0, 7, 2 * one, -3 * one, 0));           // b on plane, cut a-c
    send_tri(mk_tri(one, -one, 9, 3, 2 * one, 0, 5, 0, 5));                 // c on plane, cut a-b
    send_tri(mk_tri(0, one, 0, one, -one, 0, 2 * one, -2 * one, one));      // cuts a-b and a-c
    send_tri(mk_tri(0, one, 0, one, -one, 0, 2 * one, 3 * one, one));       // cuts a-b and b-c
    send_tri(mk_tri(0, -one, 0, one, -one, 0, 2 * one, 3 * one, one));      // cuts a-c and b-c
    send_tri(mk_tri(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                    0, 0, 0));
    send_tri(mk_tri(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                    COORD_MAX, -1, COORD_MIN));
  endtask

  // plane point far off the plane drives crossings into saturation
  task automatic test_saturation();
    set_plane(0, 65536, 0, 0, COORD_MAX, COORD_MAX, COORD_MIN);
    send_tri(mk_tri(COORD_MIN, 1, COORD_MAX, COORD_MAX, -1, COORD_MIN, 0, 2, 0));
    send_tri(mk_tri(7, COORD_MAX, -7, -7, COORD_MIN, 7, 0, 0, 0));
    send_tri(mk_tri(1, 3, 1, 1, -3, 1, 2, 5, 2));
    send_tri(mk_tri(-1, 1, 5, 9, -1, -5, 3, 0, 3));
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) send_tri(rand_tri());
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  function automatic longint rand_normal();
    return longint'($urandom_range(262144)) - 131072;
  endfunction

  function automatic longint rand_word();
    return longint'(signed'(32'($urandom)));
  endfunction

  initial begin
    nrm[0] = 0; nrm[1] = 65536; nrm[2] = 0;
    plane_off = 0;
    for (int k = 0; k < 3; k++) begin
      ppt[k] = 0;
      tgt[k] = 0;
    end
    tgt[1] = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_classes();
    test_saturation();

    set_plane(0, 65536, 0, 12345, 0, 12345, 0);
    test_random(150, 0, 0);
    set_plane(-65536, 0, 0, -70000, 70000, 0, 0);
    test_random(150, 60, 0);
    set_plane(0, 0, 131072, 262144, 0, 0, 131072);
    test_random(150, 0, 60);
    set_plane(rand_normal(), rand_normal(), rand_normal(), rand_word(),
              rand_word(), rand_word(), rand_word());
    test_random(150, 24, 24);
    set_plane(-131072, 0, 0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX);
    test_random(150, 0, 0);
    set_plane(131072, -131072, 131072, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
    test_random(150, 60, 0);
    set_plane(0, -65536, 0, -5, 3, 5, -3);
    test_random(150, 0, 60);
    set_plane(rand_normal(), rand_normal(), rand_normal(),
              longint'($urandom_range(65536)) - 32768, 0, 0, 0);
    test_random(150, 24, 24);

    wait_drained();
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
src/tps_pkg.sv
src/tps_cut_lane.sv
src/triangle_plane_slice.sv
verif/triangle_plane_slice_test.sv
